// ----- rtl/flt_pkg.sv -----
// shared types and constants for the fraction lowest-terms unit
// beat structs, divider request/response structs and sequencer states
// no dependencies
package flt_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned CntWidth  = $clog2(DataWidth);
  localparam logic [DataWidth-1:0] HalfMax = {1'b0, {(DataWidth-1){1'b1}}};

  typedef struct packed {
    logic signed [DataWidth-1:0] num_in;
    logic signed [DataWidth-1:0] den_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] num_out;
    logic [DataWidth-2:0]        den_out;
    logic                        div_error;
  } out_beat_t;

  typedef struct packed {
    logic                 start;
    logic [DataWidth-1:0] dividend;
    logic [DataWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DataWidth-1:0] quotient;
    logic [DataWidth-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_GCD,
    SEQ_GCD_WAIT,
    SEQ_QN,
    SEQ_QN_WAIT,
    SEQ_QD,
    SEQ_QD_WAIT,
    SEQ_EMIT
  } seq_state_e;

endpackage

// ----- rtl/flt_div.sv -----
// shared restoring divider, one quotient bit per cycle
// gives quotient and remainder of two unsigned words
// depends on flt_pkg
module flt_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  flt_pkg::div_req_t req_i,
  output flt_pkg::div_rsp_t rsp_o
);
  import flt_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic [DataWidth-1:0] rem_q, rem_d;
  logic [DataWidth-1:0] dvd_q, dvd_d;
  logic [DataWidth-1:0] dvs_q, dvs_d;
  logic [DataWidth:0]   rem_sh;
  logic [DataWidth:0]   diff;
  logic                 qbit;

  always_comb begin
    rem_sh = {rem_q, dvd_q[DataWidth-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    qbit   = ~diff[DataWidth];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntWidth'(DataWidth - 1);
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = qbit ? diff[DataWidth-1:0] : rem_sh[DataWidth-1:0];
      dvd_d = {dvd_q[DataWidth-2:0], qbit};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = dvd_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ----- rtl/flt_seq.sv -----
// sequencer: magnitudes, euclidean gcd loop and the two quotients
// drives the shared divider and forms the result beat
// depends on flt_pkg
module flt_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  flt_pkg::in_beat_t  in_data_i,
  output logic               busy_o,
  output logic               res_valid_o,
  output flt_pkg::out_beat_t res_data_o,
  input  logic               res_ready_i,
  output flt_pkg::div_req_t  div_req_o,
  input  flt_pkg::div_rsp_t  div_rsp_i
);
  import flt_pkg::*;

  seq_state_e state_q, state_d;

  logic [DataWidth-1:0] nmag_q, nmag_d;
  logic [DataWidth-1:0] dmag_q, dmag_d;
  logic [DataWidth-1:0] a_q, a_d;
  logic [DataWidth-1:0] b_q, b_d;
  logic [DataWidth-1:0] rn_q, rn_d;
  logic [DataWidth-1:0] rd_q, rd_d;
  logic                 neg_q, neg_d;
  logic                 err_q, err_d;

  logic                 n_neg, d_neg;
  logic [DataWidth-1:0] n_mag, d_mag;

  always_comb begin
    n_neg = in_data_i.num_in[DataWidth-1];
    d_neg = in_data_i.den_in[DataWidth-1];
    n_mag = n_neg ? (~in_data_i.num_in + 1'b1) : in_data_i.num_in;
    d_mag = d_neg ? (~in_data_i.den_in + 1'b1) : in_data_i.den_in;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (in_valid_i) begin
          state_d = (d_mag == '0) ? SEQ_EMIT : SEQ_GCD;
        end
      end
      SEQ_GCD:      state_d = (b_q == '0) ? SEQ_QN : SEQ_GCD_WAIT;
      SEQ_GCD_WAIT: if (div_rsp_i.done) state_d = SEQ_GCD;
      SEQ_QN:       state_d = SEQ_QN_WAIT;
      SEQ_QN_WAIT:  if (div_rsp_i.done) state_d = SEQ_QD;
      SEQ_QD:       state_d = SEQ_QD_WAIT;
      SEQ_QD_WAIT:  if (div_rsp_i.done) state_d = SEQ_EMIT;
      SEQ_EMIT:     if (res_ready_i) state_d = SEQ_IDLE;
      default:      state_d = SEQ_IDLE;
    endcase
  end

  // divider requests and datapath updates
  always_comb begin
    div_req_o.start    = 1'b0;
    div_req_o.dividend = a_q;
    div_req_o.divisor  = b_q;
    nmag_d = nmag_q;
    dmag_d = dmag_q;
    a_d    = a_q;
    b_d    = b_q;
    rn_d   = rn_q;
    rd_d   = rd_q;
    neg_d  = neg_q;
    err_d  = err_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (in_valid_i) begin
          nmag_d = n_mag;
          dmag_d = d_mag;
          a_d    = n_mag;
          b_d    = d_mag;
          neg_d  = n_neg ^ d_neg;
          err_d  = (d_mag == '0);
        end
      end
      SEQ_GCD: begin
        div_req_o.start = (b_q != '0);
      end
      SEQ_GCD_WAIT: begin
        if (div_rsp_i.done) begin
          a_d = b_q;
          b_d = div_rsp_i.remainder;
        end
      end
      SEQ_QN: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = nmag_q;
        div_req_o.divisor  = a_q;
      end
      SEQ_QN_WAIT: begin
        if (div_rsp_i.done) rn_d = div_rsp_i.quotient;
      end
      SEQ_QD: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = dmag_q;
        div_req_o.divisor  = a_q;
      end
      SEQ_QD_WAIT: begin
        if (div_rsp_i.done) rd_d = div_rsp_i.quotient;
      end
      SEQ_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // result beat with sign and saturation
  always_comb begin
    res_valid_o = (state_q == SEQ_EMIT);
    busy_o      = (state_q != SEQ_IDLE);
    if (err_q) begin
      res_data_o.num_out   = '0;
      res_data_o.den_out   = '0;
      res_data_o.div_error = 1'b1;
    end else begin
      res_data_o.div_error = 1'b0;
      res_data_o.den_out   = rd_q[DataWidth-1] ? HalfMax[DataWidth-2:0]
                                               : rd_q[DataWidth-2:0];
      if (neg_q && (rn_q != '0)) begin
        res_data_o.num_out = ~rn_q + 1'b1;
      end else begin
        res_data_o.num_out = rn_q[DataWidth-1] ? HalfMax : rn_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nmag_q <= nmag_d;
    dmag_q <= dmag_d;
    a_q    <= a_d;
    b_q    <= b_d;
    rn_q   <= rn_d;
    rd_q   <= rd_d;
    neg_q  <= neg_d;
    err_q  <= err_d;
  end

endmodule

// ----- rtl/fraction_lowest_terms_unit.sv -----
// fraction lowest-terms unit, top level with the output register
// instantiates flt_seq and flt_div, depends on flt_pkg
//
// usage:
//   input channel in_valid_i / in_stall_o carries a numerator and a
//   denominator per beat; output channel out_valid_o / out_stall_i carries
//   the reduced numerator, positive denominator and a zero-divide flag.
//   a beat moves on a rising edge where valid is high and stall is low.
//   one input beat yields exactly one output beat.
// operation:
//   the gcd is found by repeated remainder on one shared bit-serial
//   divider, then the same divider forms both quotients. the number of
//   remainder steps is at most about 46 for 32-bit words. a zero
//   denominator skips the divider and goes straight to the result.
//   in_stall_o is high for the whole time one item is in work.
// reset and stall:
//   reset empties the sequencer and the output register. while the
//   receiver stalls, the held output beat stays put, the next item may
//   still be taken and worked on, and its result waits in the sequencer.
module fraction_lowest_terms_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  flt_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output flt_pkg::out_beat_t out_data_o
);
  import flt_pkg::*;

  logic      busy;
  logic      res_valid;
  logic      res_ready;
  out_beat_t res_data;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  logic      out_valid_q, out_valid_d;
  out_beat_t out_data_q, out_data_d;

  flt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_data_o  (res_data),
    .res_ready_i (res_ready),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  flt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o = busy;
  assign res_ready  = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = (res_valid && res_ready) || (out_valid_q && out_stall_i);
    out_data_d  = (res_valid && res_ready) ? res_data : out_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.div_error |->
      (out_data_o.num_out == '0) && (out_data_o.den_out == '0))
    else $error("error beat with nonzero fraction");

  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.div_error |-> (out_data_o.den_out != '0))
    else $error("zero denominator without error flag");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepted beat");
`endif

endmodule
